// ===== sv/pqbf_pkg.sv =====
// package for the per-agent quota bounded forwarder
// widths, status codes, register indexes and controller/datapath structs
// no dependencies
`default_nettype none

package pqbf_pkg;

  localparam int FIFO_DEPTH    = 64;
  localparam int AGENT_BITS    = 16;
  localparam int PAYLOAD_BITS  = 32;

  localparam int PTR_W  = $clog2(FIFO_DEPTH);
  localparam int LVL_W  = $clog2(FIFO_DEPTH + 1);
  localparam int CFG_W  = 7;
  localparam int CMP_W  = (LVL_W > CFG_W) ? LVL_W : CFG_W;
  localparam int STAT_W = 32;
  localparam int ST_W   = 3;
  localparam int IDX_W  = 1;

  localparam logic [ST_W-1:0] ST_QUEUED  = 3'd0;
  localparam logic [ST_W-1:0] ST_QUOTA   = 3'd1;
  localparam logic [ST_W-1:0] ST_FULL    = 3'd2;
  localparam logic [ST_W-1:0] ST_DRAINED = 3'd3;
  localparam logic [ST_W-1:0] ST_EMPTY   = 3'd4;

  localparam logic [IDX_W-1:0] CFG_AGENT_QUOTA = 1'd0;
  localparam logic [IDX_W-1:0] CFG_QUEUE_LIMIT = 1'd1;

  localparam logic [CFG_W-1:0] AGENT_QUOTA_RST = 7'd4;
  localparam logic [CFG_W-1:0] QUEUE_LIMIT_RST = 7'd64;

  typedef struct packed {
    logic [AGENT_BITS-1:0]   agent;
    logic [PAYLOAD_BITS-1:0] payload;
  } fifo_entry_t;

  // commands from controller to datapath
  typedef struct packed {
    logic accept;
    logic look;
    logic enc;
    logic exec;
  } pqbf_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic out_free;
  } pqbf_sts_t;

endpackage

`default_nettype wire

// ===== sv/pqbf_in_if.sv =====
// request channel interface: valid/ready plus request fields
// depends on pqbf_pkg
`default_nettype none

interface pqbf_in_if;
  logic                              valid;
  logic                              ready;
  logic                              req_type;
  logic [pqbf_pkg::AGENT_BITS-1:0]   agent;
  logic [pqbf_pkg::PAYLOAD_BITS-1:0] payload_tag;
  logic                              sink_ok;

  modport source (output valid, req_type, agent, payload_tag, sink_ok, input ready);
  modport sink   (input valid, req_type, agent, payload_tag, sink_ok, output ready);
endinterface

`default_nettype wire

// ===== sv/pqbf_out_if.sv =====
// result channel interface: valid/ready plus result fields
// depends on pqbf_pkg
`default_nettype none

interface pqbf_out_if;
  logic                              valid;
  logic                              ready;
  logic [pqbf_pkg::ST_W-1:0]         status;
  logic [pqbf_pkg::AGENT_BITS-1:0]   out_agent;
  logic [pqbf_pkg::PAYLOAD_BITS-1:0] out_payload;
  logic [pqbf_pkg::LVL_W-1:0]        agent_level;
  logic [pqbf_pkg::LVL_W-1:0]        queue_level;
  logic [pqbf_pkg::LVL_W-1:0]        tracked_count;
  logic [pqbf_pkg::STAT_W-1:0]       quota_drops;
  logic [pqbf_pkg::STAT_W-1:0]       full_drops;
  logic [pqbf_pkg::STAT_W-1:0]       forwarded;
  logic [pqbf_pkg::STAT_W-1:0]       sink_failures;

  modport source (output valid, status, out_agent, out_payload, agent_level, queue_level,
                  tracked_count, quota_drops, full_drops, forwarded, sink_failures,
                  input ready);
  modport sink   (input valid, status, out_agent, out_payload, agent_level, queue_level,
                  tracked_count, quota_drops, full_drops, forwarded, sink_failures,
                  output ready);
endinterface

`default_nettype wire

// ===== sv/pqbf_ctrl.sv =====
// controller: sequences accept, key compare, encode/count read and execute
// depends on pqbf_pkg
`default_nettype none

module pqbf_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire pqbf_pkg::pqbf_sts_t sts,
  output logic                     in_ready,
  output pqbf_pkg::pqbf_cmd_t      cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_ENC,
    S_EXEC
  } state_t;

  state_t state_r;
  logic   ready_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ready_r <= 1'b1;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && ready_r) begin
            state_r <= S_LOOK;
            ready_r <= 1'b0;
          end
        end
        S_LOOK: state_r <= S_ENC;
        S_ENC:  state_r <= S_EXEC;
        S_EXEC: begin
          // hold until the result register can take the new result
          if (sts.out_free) begin
            state_r <= S_IDLE;
            ready_r <= 1'b1;
          end
        end
        default: begin
          state_r <= S_IDLE;
          ready_r <= 1'b1;
        end
      endcase
    end
  end

  assign in_ready   = ready_r;
  assign cmd.accept = in_valid && ready_r;
  assign cmd.look   = (state_r == S_LOOK);
  assign cmd.enc    = (state_r == S_ENC);
  assign cmd.exec   = (state_r == S_EXEC) && sts.out_free;

endmodule

`default_nettype wire

// ===== sv/pqbf_dp.sv =====
// datapath: agent table (key match array, count memory), event fifo memory,
// statistics, configuration registers and the result register; depends on pqbf_pkg
`default_nettype none

module pqbf_dp (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire pqbf_pkg::pqbf_cmd_t               cmd,
  output pqbf_pkg::pqbf_sts_t                    sts,
  input  wire logic                              in_req_type,
  input  wire logic [pqbf_pkg::AGENT_BITS-1:0]   in_agent,
  input  wire logic [pqbf_pkg::PAYLOAD_BITS-1:0] in_payload_tag,
  input  wire logic                              in_sink_ok,
  input  wire logic                              cfg_we,
  input  wire logic [pqbf_pkg::IDX_W-1:0]        cfg_index,
  input  wire logic [pqbf_pkg::CFG_W-1:0]        cfg_wdata,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [pqbf_pkg::ST_W-1:0]              out_status,
  output logic [pqbf_pkg::AGENT_BITS-1:0]        out_agent,
  output logic [pqbf_pkg::PAYLOAD_BITS-1:0]      out_payload,
  output logic [pqbf_pkg::LVL_W-1:0]             out_agent_level,
  output logic [pqbf_pkg::LVL_W-1:0]             out_queue_level,
  output logic [pqbf_pkg::LVL_W-1:0]             out_tracked_count,
  output logic [pqbf_pkg::STAT_W-1:0]            out_quota_drops,
  output logic [pqbf_pkg::STAT_W-1:0]            out_full_drops,
  output logic [pqbf_pkg::STAT_W-1:0]            out_forwarded,
  output logic [pqbf_pkg::STAT_W-1:0]            out_sink_failures
);

  localparam int DEPTH = pqbf_pkg::FIFO_DEPTH;
  localparam int PTR_W = pqbf_pkg::PTR_W;
  localparam int LVL_W = pqbf_pkg::LVL_W;
  localparam int CMP_W = pqbf_pkg::CMP_W;
  localparam int AG_W  = pqbf_pkg::AGENT_BITS;
  localparam int PL_W  = pqbf_pkg::PAYLOAD_BITS;
  localparam int SW    = pqbf_pkg::STAT_W;

  function automatic logic [SW-1:0] sat_inc(input logic [SW-1:0] v);
    sat_inc = (&v) ? v : v + 1'b1;
  endfunction

  // configuration
  logic [pqbf_pkg::CFG_W-1:0] agent_quota_r;
  logic [pqbf_pkg::CFG_W-1:0] queue_limit_r;

  // latched request
  logic            req_type_r;
  logic [AG_W-1:0] req_agent_r;
  logic [PL_W-1:0] req_payload_r;
  logic            req_sink_ok_r;

  // event fifo
  pqbf_pkg::fifo_entry_t fifo_mem [DEPTH];
  pqbf_pkg::fifo_entry_t fifo_rd_r;
  logic [PTR_W-1:0]      head_r;
  logic [PTR_W-1:0]      tail_r;
  logic [LVL_W-1:0]      level_r;

  // agent table
  logic [AG_W-1:0]  agent_keys_r [DEPTH];
  logic [DEPTH-1:0] agent_valid_r;
  logic [LVL_W-1:0] cnt_mem [DEPTH];
  logic [LVL_W-1:0] cnt_rd_r;
  logic [LVL_W-1:0] tracked_r;

  // lookup pipeline
  logic             pop_r;
  logic [AG_W-1:0]  key_r;
  logic [PL_W-1:0]  pop_payload_r;
  logic [DEPTH-1:0] match_r;
  logic [PTR_W-1:0] slot_r;
  logic [PTR_W-1:0] free_slot_r;
  logic             hit_r;
  logic             any_free_r;

  // statistics
  logic [SW-1:0] quota_drops_r;
  logic [SW-1:0] full_drops_r;
  logic [SW-1:0] forwarded_r;
  logic [SW-1:0] sink_failures_r;

  // result register
  logic                      out_valid_r;
  logic [pqbf_pkg::ST_W-1:0] res_status_r;
  logic [AG_W-1:0]           res_agent_r;
  logic [PL_W-1:0]           res_payload_r;
  logic [LVL_W-1:0]          res_level_r;

  // combinational
  logic             pop_nxt;
  logic [AG_W-1:0]  key_nxt;
  logic [DEPTH-1:0] match_nxt;
  logic [PTR_W-1:0] enc_idx;
  logic [DEPTH-1:0] free_vec;
  logic [DEPTH-1:0] free_one;
  logic [PTR_W-1:0] free_idx;

  logic [LVL_W-1:0]          ex_cnt;
  logic [CMP_W-1:0]          ex_cap;
  logic [pqbf_pkg::ST_W-1:0] ex_status;
  logic [PL_W-1:0]           ex_payload;
  logic [LVL_W-1:0]          ex_level;
  logic                      ex_push;
  logic                      ex_pop;
  logic                      ex_cnt_we;
  logic [PTR_W-1:0]          ex_cnt_slot;
  logic [LVL_W-1:0]          ex_cnt_wdata;
  logic                      ex_new_entry;
  logic                      ex_release;
  logic                      ex_bump_quota;
  logic                      ex_bump_full;
  logic                      ex_bump_fwd;
  logic                      ex_bump_fail;
  logic [LVL_W-1:0]          tracked_nxt;
  logic [LVL_W-1:0]          level_nxt;

  assign sts.out_free = !out_valid_r || out_ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      agent_quota_r <= pqbf_pkg::AGENT_QUOTA_RST;
      queue_limit_r <= pqbf_pkg::QUEUE_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pqbf_pkg::CFG_AGENT_QUOTA: agent_quota_r <= cfg_wdata;
        pqbf_pkg::CFG_QUEUE_LIMIT: queue_limit_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // key for the lookup: head agent on a pop, request agent otherwise
  always_comb begin
    pop_nxt = req_type_r && (level_r != '0);
    key_nxt = pop_nxt ? fifo_rd_r.agent : req_agent_r;
    for (int i = 0; i < DEPTH; i++) begin
      match_nxt[i] = agent_valid_r[i] && (agent_keys_r[i] == key_nxt);
    end
  end

  // at most one entry matches, so an or of the indexes encodes it
  always_comb begin
    enc_idx  = '0;
    free_idx = '0;
    free_vec = ~agent_valid_r;
    free_one = free_vec & (~free_vec + 1'b1);
    for (int i = 0; i < DEPTH; i++) begin
      enc_idx  = enc_idx  | (match_r[i]  ? PTR_W'(i) : '0);
      free_idx = free_idx | (free_one[i] ? PTR_W'(i) : '0);
    end
  end

  always_ff @(posedge clk) begin
    fifo_rd_r <= fifo_mem[head_r];
    if (cmd.accept) begin
      req_type_r    <= in_req_type;
      req_agent_r   <= in_agent;
      req_payload_r <= in_payload_tag;
      req_sink_ok_r <= in_sink_ok;
    end
    if (cmd.look) begin
      pop_r         <= pop_nxt;
      key_r         <= key_nxt;
      pop_payload_r <= fifo_rd_r.payload;
      match_r       <= match_nxt;
    end
    if (cmd.enc) begin
      slot_r      <= enc_idx;
      hit_r       <= |match_r;
      free_slot_r <= free_idx;
      any_free_r  <= |free_vec;
      cnt_rd_r    <= cnt_mem[enc_idx];
    end
  end

  // execute step
  always_comb begin
    ex_cnt = hit_r ? cnt_rd_r : '0;
    ex_cap = (CMP_W'(queue_limit_r) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(queue_limit_r);
    ex_status     = pqbf_pkg::ST_QUEUED;
    ex_payload    = '0;
    ex_level      = ex_cnt;
    ex_push       = 1'b0;
    ex_pop        = 1'b0;
    ex_cnt_we     = 1'b0;
    ex_cnt_slot   = slot_r;
    ex_cnt_wdata  = ex_cnt;
    ex_new_entry  = 1'b0;
    ex_release    = 1'b0;
    ex_bump_quota = 1'b0;
    ex_bump_full  = 1'b0;
    ex_bump_fwd   = 1'b0;
    ex_bump_fail  = 1'b0;
    if (!req_type_r) begin
      if (CMP_W'(ex_cnt) >= CMP_W'(agent_quota_r)) begin
        ex_status     = pqbf_pkg::ST_QUOTA;
        ex_bump_quota = 1'b1;
      end else if ((CMP_W'(level_r) >= ex_cap) || (!hit_r && !any_free_r)) begin
        ex_status    = pqbf_pkg::ST_FULL;
        ex_bump_full = 1'b1;
      end else begin
        ex_status    = pqbf_pkg::ST_QUEUED;
        ex_push      = 1'b1;
        ex_cnt_we    = 1'b1;
        ex_cnt_slot  = hit_r ? slot_r : free_slot_r;
        ex_cnt_wdata = ex_cnt + 1'b1;
        ex_new_entry = !hit_r;
        ex_level     = ex_cnt + 1'b1;
      end
    end else if (!pop_r) begin
      ex_status = pqbf_pkg::ST_EMPTY;
    end else begin
      ex_status    = pqbf_pkg::ST_DRAINED;
      ex_payload   = pop_payload_r;
      ex_pop       = 1'b1;
      ex_bump_fwd  = req_sink_ok_r;
      ex_bump_fail = !req_sink_ok_r;
      if (hit_r) begin
        ex_cnt_we    = 1'b1;
        ex_cnt_wdata = (ex_cnt != '0) ? ex_cnt - 1'b1 : '0;
        ex_release   = (ex_cnt_wdata == '0);
        ex_level     = ex_cnt_wdata;
      end else begin
        ex_level = '0;
      end
    end
    tracked_nxt = tracked_r + LVL_W'(ex_new_entry) - LVL_W'(ex_release);
    level_nxt   = level_r + LVL_W'(ex_push) - LVL_W'(ex_pop);
  end

  // memories and key array (no reset)
  always_ff @(posedge clk) begin
    if (cmd.exec && ex_push) begin
      fifo_mem[tail_r] <= '{agent: req_agent_r, payload: req_payload_r};
    end
    if (cmd.exec && ex_cnt_we) begin
      cnt_mem[ex_cnt_slot] <= ex_cnt_wdata;
    end
    if (cmd.exec && ex_new_entry) begin
      agent_keys_r[free_slot_r] <= req_agent_r;
    end
  end

  // control state and statistics
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r          <= '0;
      tail_r          <= '0;
      level_r         <= '0;
      agent_valid_r   <= '0;
      tracked_r       <= '0;
      quota_drops_r   <= '0;
      full_drops_r    <= '0;
      forwarded_r     <= '0;
      sink_failures_r <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cmd.exec) begin
        if (ex_push) begin
          tail_r <= (tail_r == PTR_W'(DEPTH - 1)) ? '0 : tail_r + 1'b1;
        end
        if (ex_pop) begin
          head_r <= (head_r == PTR_W'(DEPTH - 1)) ? '0 : head_r + 1'b1;
        end
        if (ex_new_entry) begin
          agent_valid_r[free_slot_r] <= 1'b1;
        end
        if (ex_release) begin
          agent_valid_r[slot_r] <= 1'b0;
        end
        level_r   <= level_nxt;
        tracked_r <= tracked_nxt;
        if (ex_bump_quota) quota_drops_r   <= sat_inc(quota_drops_r);
        if (ex_bump_full)  full_drops_r    <= sat_inc(full_drops_r);
        if (ex_bump_fwd)   forwarded_r     <= sat_inc(forwarded_r);
        if (ex_bump_fail)  sink_failures_r <= sat_inc(sink_failures_r);
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_status_r  <= ex_status;
      res_agent_r   <= key_r;
      res_payload_r <= ex_payload;
      res_level_r   <= ex_level;
    end
  end

  // statistics and levels are held in registers that change only on execute,
  // so they read the same as a snapshot until the next result is loaded
  assign out_valid         = out_valid_r;
  assign out_status        = res_status_r;
  assign out_agent         = res_agent_r;
  assign out_payload       = res_payload_r;
  assign out_agent_level   = res_level_r;
  assign out_queue_level   = level_r;
  assign out_tracked_count = tracked_r;
  assign out_quota_drops   = quota_drops_r;
  assign out_full_drops    = full_drops_r;
  assign out_forwarded     = forwarded_r;
  assign out_sink_failures = sink_failures_r;

endmodule

`default_nettype wire

// ===== sv/per_agent_quota_bounded_forwarder.sv =====
// top level of the per-agent quota bounded forwarder
// instantiates pqbf_ctrl and pqbf_dp; uses pqbf_pkg, pqbf_in_if, pqbf_out_if
//
//   channel  dir  handshake           contents
//   in_ch    in   valid/ready         req_type, agent, payload_tag, sink_ok
//   out_ch   out  valid/ready         status, agent, payload, levels, statistics
//   cfg_*    in   cfg_we, no stall    cfg_index, cfg_wdata (agent quota, queue limit)
//
// one request at a time: accept, key match over the agent table,
// index encode with count memory read, then execute with the result registered
// execute waits while the result register still holds an untaken result
// the next request is accepted while a result waits on out_ch
// synchronous active-low reset clears valid bits, pointers, levels and statistics;
// no clearing pass over the memories
`default_nettype none

module per_agent_quota_bounded_forwarder (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  pqbf_in_if.sink                         in_ch,
  pqbf_out_if.source                      out_ch,
  input  wire logic                       cfg_we,
  input  wire logic [pqbf_pkg::IDX_W-1:0] cfg_index,
  input  wire logic [pqbf_pkg::CFG_W-1:0] cfg_wdata
);

  pqbf_pkg::pqbf_cmd_t cmd;
  pqbf_pkg::pqbf_sts_t sts;
  logic                in_ready;

  pqbf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .sts      (sts),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  assign in_ch.ready = in_ready;

  pqbf_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_req_type       (in_ch.req_type),
    .in_agent          (in_ch.agent),
    .in_payload_tag    (in_ch.payload_tag),
    .in_sink_ok        (in_ch.sink_ok),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_status        (out_ch.status),
    .out_agent         (out_ch.out_agent),
    .out_payload       (out_ch.out_payload),
    .out_agent_level   (out_ch.agent_level),
    .out_queue_level   (out_ch.queue_level),
    .out_tracked_count (out_ch.tracked_count),
    .out_quota_drops   (out_ch.quota_drops),
    .out_full_drops    (out_ch.full_drops),
    .out_forwarded     (out_ch.forwarded),
    .out_sink_failures (out_ch.sink_failures)
  );

endmodule

`default_nettype wire
